### design/dcrp_pkg.sv
package dcrp_pkg;

	localparam int MAX_POSITIONS = 64;
	localparam int TOKEN_BITS    = 24;
	localparam int POS_W         = $clog2(MAX_POSITIONS);
	localparam int LEN_W         = POS_W + 1;

	// shared divider sizing: dividend holds a step count or (n - k) * 2^17 + n, divisor holds a period or 2n
	localparam int DIV_W     = LEN_W + 17;
	localparam int DIVR_W    = 17;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [2:0] OP_PLAN_TOKEN    = 3'd0;
	localparam logic [2:0] OP_PLAN_END      = 3'd1;
	localparam logic [2:0] OP_OBSERVE_CLEAR = 3'd2;
	localparam logic [2:0] OP_OBSERVE_TOKEN = 3'd3;
	localparam logic [2:0] OP_OBSERVE_END   = 3'd4;

	localparam logic [1:0] CFG_MODE_DELTA = 2'd0;
	localparam logic [1:0] CFG_PERIOD     = 2'd1;
	localparam logic [1:0] CFG_FRACTION   = 2'd2;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0]  quotient;
		logic [DIVR_W-1:0] remainder;
	} div_rsp_t;

endpackage

### design/dcrp_ram.sv
module dcrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/dcrp_div.sv
module dcrp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  dcrp_pkg::div_req_t  req,
	output dcrp_pkg::div_rsp_t  rsp
);
	import dcrp_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     sh_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [DIVR_W-1:0]    den_q;
	logic [DIVR_W:0]      trial;
	logic                 ge;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, sh_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q  <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIVR_W'(trial - {1'b0, den_q}) : trial[DIVR_W-1:0];
			sh_q  <= {sh_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = sh_q;
	assign rsp.remainder = rem_q;

endmodule

### design/delta_cache_refresh_planner.sv
// delta cache refresh planner
// input channel (in_valid / in_stall) takes one op per beat; the block stalls
// the input while it works on an item. observe token, observe clear, observe
// end and unknown ops finish in idle; a plan token passes through a compare
// state (token memory read, then compare). a plan end runs a sequencer: a churn
// scan, a step-modulo on the shared shift-subtract divider (skipped for a zero
// period), a select count, a hit-ratio divide on the same divider (skipped for
// an empty board), then an emit scan that sends one beat per recompute position
// in ascending order, last set on the final beat, and stops at the last selected
// position (a single beat with no position for an empty list). cache off or cold
// gives a single beat. results sit in an output register, so out_stall only
// holds the emit scan or the single cold beat; the block returns to idle once
// the last beat is loaded. config (cfg_valid / cfg_ready) is always ready and
// should be written only while idle. reset clears valid bits, change marks,
// board length, frozen bound and cache-present at once; token memory contents
// are read only where the valid bit is set, so no clearing pass is needed.
module delta_cache_refresh_planner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          op,
	input  logic [dcrp_pkg::POS_W-1:0]          position,
	input  logic [dcrp_pkg::TOKEN_BITS-1:0]     token,
	input  logic [6:0]                          active_lo,
	input  logic [6:0]                          active_hi,
	input  logic [15:0]                         step_count,
	input  logic                                freeze_en,
	input  logic                                has_active,
	input  logic                                kv_valid,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                reuse,
	output logic                                has_position,
	output logic [dcrp_pkg::POS_W-1:0]          recompute_position,
	output logic                                last,
	output logic [16:0]                         cache_hit_q16,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [16:0]                         cfg_data
);
	import dcrp_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_TOK    = 3'd1;
	localparam logic [2:0] S_CHURN  = 3'd2;
	localparam logic [2:0] S_MODW   = 3'd3;
	localparam logic [2:0] S_SELCNT = 3'd4;
	localparam logic [2:0] S_HITW   = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;
	localparam logic [2:0] S_COLD   = 3'd7;

	logic [2:0] state_q;

	logic        mode_q;
	logic [15:0] period_q;
	logic [16:0] frac_q;

	logic [MAX_POSITIONS-1:0] valid_q;
	logic [MAX_POSITIONS-1:0] changed_q;
	logic [LEN_W-1:0]         board_len_q;
	logic [LEN_W-1:0]         frozen_bound_q;
	logic                     present_q;

	logic [POS_W-1:0]      pos_q;
	logic [TOKEN_BITS-1:0] tok_q;
	logic [6:0]            lo_q;
	logic [6:0]            hi_q;
	logic [15:0]           step_q;
	logic                  fz_q;
	logic [POS_W-1:0]      p_q;
	logic [LEN_W-1:0]      wchg_q;
	logic [LEN_W-1:0]      k_q;
	logic [LEN_W-1:0]      cnt_q;
	logic                  churn_full_q;
	logic                  full_q;
	logic [16:0]           hit_q;

	logic                  ov_q;
	logic                  o_reuse_q;
	logic                  o_has_q;
	logic [POS_W-1:0]      o_pos_q;
	logic                  o_last_q;
	logic [16:0]           o_hit_q;

	logic                  in_acc;
	logic                  ram_we;
	logic [TOKEN_BITS-1:0] ram_rdata;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	logic [LEN_W-1:0] p_ext;
	logic             frozen_p;
	logic             sel_p;
	logic             win_p;
	logic [6:0]       wsize;
	logic [LEN_W-1:0] wchg_all;
	logic [23:0]      churn_rhs;
	logic [23:0]      churn_lhs;
	logic             churn_over;
	logic             scan_end;
	logic             slot_free;
	logic             load;
	logic             l_reuse;
	logic             l_has;
	logic             l_last;
	logic [16:0]      l_hit;
	logic             finish;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign ram_we    = in_acc && op == OP_OBSERVE_TOKEN;

	dcrp_ram #(.WIDTH(TOKEN_BITS), .DEPTH(MAX_POSITIONS)) u_tok_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (position),
		.wdata (token),
		.raddr (position),
		.rdata (ram_rdata)
	);

	dcrp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// per-position decode at the scan pointer
	assign p_ext    = {1'b0, p_q};
	assign frozen_p = fz_q && p_ext < frozen_bound_q;
	assign win_p    = p_ext >= lo_q && p_ext < hi_q && changed_q[p_q] && !frozen_p;
	assign sel_p    = p_ext < board_len_q && !frozen_p &&
	                  (full_q || !valid_q[p_q] || changed_q[p_q]);
	assign scan_end = p_q == POS_W'(MAX_POSITIONS - 1);

	// count includes the position under the pointer on the last scan cycle
	assign wsize      = hi_q > lo_q ? 7'(hi_q - lo_q) : 7'd0;
	assign wchg_all   = wchg_q + LEN_W'(win_p);
	assign churn_lhs  = {1'b0, wchg_all, 16'd0};
	assign churn_rhs  = 24'(frac_q) * 24'(wsize);
	assign churn_over = wsize != 7'd0 && churn_lhs > churn_rhs;

	assign slot_free = !ov_q || !out_stall;

	always_comb begin
		load    = 1'b0;
		l_reuse = 1'b1;
		l_has   = 1'b0;
		l_last  = 1'b1;
		l_hit   = hit_q;
		finish  = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = DIV_W'(step_q);
		div_req.divisor  = DIVR_W'(period_q);
		unique case (state_q)
			S_CHURN: begin
				if (scan_end && period_q != 16'd0) begin
					div_req.start = 1'b1;
				end
			end
			S_SELCNT: begin
				if (scan_end && board_len_q != '0) begin
					div_req.start    = 1'b1;
					div_req.dividend = {7'(board_len_q - (k_q + LEN_W'(sel_p))), 17'd0}
					                   + DIV_W'(board_len_q);
					div_req.divisor  = DIVR_W'({board_len_q, 1'b0});
				end
			end
			S_EMIT: begin
				if (k_q == '0) begin
					load   = slot_free;
					finish = slot_free;
				end else if (sel_p && slot_free) begin
					load   = 1'b1;
					l_has  = 1'b1;
					l_last = cnt_q + 1'b1 == k_q;
					finish = l_last;
				end
			end
			S_COLD: begin
				load    = slot_free;
				finish  = slot_free;
				l_reuse = 1'b0;
				l_hit   = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mode_q         <= 1'b0;
			period_q       <= 16'd1;
			frac_q         <= '0;
			valid_q        <= '0;
			changed_q      <= '0;
			board_len_q    <= '0;
			frozen_bound_q <= '0;
			present_q      <= 1'b0;
			ov_q           <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MODE_DELTA: mode_q   <= cfg_data[0];
					CFG_PERIOD:     period_q <= cfg_data[15:0];
					CFG_FRACTION:   frac_q   <= cfg_data;
					default: begin
					end
				endcase
			end

			if (load) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end

			if (finish) begin
				changed_q   <= '0;
				board_len_q <= '0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (op)
							OP_PLAN_TOKEN: begin
								if ({1'b0, position} + 1'b1 > board_len_q) begin
									board_len_q <= {1'b0, position} + 1'b1;
								end
								state_q <= S_TOK;
							end
							OP_PLAN_END: begin
								state_q <= (mode_q && present_q) ? S_CHURN : S_COLD;
							end
							OP_OBSERVE_CLEAR: valid_q <= '0;
							OP_OBSERVE_TOKEN: valid_q[position] <= 1'b1;
							OP_OBSERVE_END: begin
								present_q <= kv_valid;
								if (freeze_en && has_active) begin
									frozen_bound_q <= active_lo;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_TOK: begin
					if (valid_q[pos_q] && ram_rdata != tok_q) begin
						changed_q[pos_q] <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_CHURN: begin
					if (scan_end) begin
						state_q <= period_q != 16'd0 ? S_MODW : S_SELCNT;
					end
				end
				S_MODW: begin
					if (div_rsp.done) begin
						state_q <= S_SELCNT;
					end
				end
				S_SELCNT: begin
					if (scan_end) begin
						state_q <= board_len_q != '0 ? S_HITW : S_EMIT;
					end
				end
				S_HITW: begin
					if (div_rsp.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				S_COLD: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_q  <= position;
			tok_q  <= token;
			lo_q   <= active_lo;
			hi_q   <= active_hi;
			step_q <= step_count;
			fz_q   <= freeze_en;
			p_q    <= '0;
			wchg_q <= '0;
			k_q    <= '0;
			cnt_q  <= '0;
			hit_q  <= '0;
		end
		case (state_q)
			S_CHURN: begin
				if (win_p) begin
					wchg_q <= wchg_q + 1'b1;
				end
				p_q <= p_q + 1'b1;
				if (scan_end) begin
					churn_full_q <= churn_over;
					full_q       <= churn_over || (period_q == 16'd0 && step_q == 16'd0);
				end
			end
			S_MODW: begin
				if (div_rsp.done) begin
					full_q <= churn_full_q || div_rsp.remainder == '0;
				end
			end
			S_SELCNT: begin
				if (sel_p) begin
					k_q <= k_q + 1'b1;
				end
				p_q <= p_q + 1'b1;
			end
			S_HITW: begin
				if (div_rsp.done) begin
					hit_q <= div_rsp.quotient[16:0];
				end
			end
			S_EMIT: begin
				if (!sel_p || load) begin
					p_q <= p_q + 1'b1;
				end
				if (load) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (load) begin
			o_reuse_q <= l_reuse;
			o_has_q   <= l_has;
			o_pos_q   <= l_has ? p_q : '0;
			o_last_q  <= l_last;
			o_hit_q   <= l_hit;
		end
	end

	assign out_valid          = ov_q;
	assign reuse              = o_reuse_q;
	assign has_position       = o_has_q;
	assign recompute_position = o_pos_q;
	assign last               = o_last_q;
	assign cache_hit_q16      = o_hit_q;

`ifndef SYNTHESIS
	a_tok_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TOK |-> $past(state_q) == S_IDLE)
		else $error("token compare not entered from idle");
	a_plan_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && op == OP_PLAN_END |=> state_q != S_IDLE)
		else $error("plan end did not start the sequencer");
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_position |-> last)
		else $error("beat without position is not last");
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_MODW || state_q == S_HITW))
		else $error("divider finished outside a wait state");
`endif

endmodule

### bench/tb_delta_cache_refresh_planner.sv
`timescale 1ns / 100ps

module tb_delta_cache_refresh_planner;
	import dcrp_pkg::*;

	typedef struct packed {
		logic        reuse;
		logic        has_position;
		logic [5:0]  recompute_position;
		logic        last;
		logic [16:0] cache_hit_q16;
	} plan_beat_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  op;
	logic [5:0]  position;
	logic [23:0] token;
	logic [6:0]  active_lo;
	logic [6:0]  active_hi;
	logic [15:0] step_count;
	logic        freeze_en;
	logic        has_active;
	logic        kv_valid;
	logic        out_valid;
	logic        out_stall;
	logic        reuse;
	logic        has_position;
	logic [5:0]  recompute_position;
	logic        last;
	logic [16:0] cache_hit_q16;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [16:0] cfg_data;

	// predictor state
	logic        m_delta;
	logic [15:0] m_period;
	logic [16:0] m_fraction;
	logic [23:0] c_token [64];
	logic [63:0] c_valid;
	logic [63:0] c_changed;
	logic [6:0]  c_len;
	logic [6:0]  c_frozen;
	logic        c_present;

	plan_beat_t  plan_beats_q[$];
	int          errors = 0;
	int          stall_long = 0;
	int          stall_left = 0;

	delta_cache_refresh_planner i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#100ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver stall runs, mostly short, with quiet stretches
	always @(posedge clk) begin
		if (stall_long > 0) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = gap_len();
		end
	end

	always @(posedge clk) begin
		plan_beat_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{reuse, has_position, recompute_position, last, cache_hit_q16};
			if (plan_beats_q.size() == 0) begin
				$display("%0t unexpected beat: got %p", $time, got);
				errors++;
			end else begin
				want = plan_beats_q.pop_front();
				if (got !== want) begin
					$display("%0t beat mismatch: expected %p actual %p", $time, want, got);
					errors++;
				end
			end
		end
	end

	task automatic predict_plan_end(logic [6:0] lo, logic [6:0] hi, logic [15:0] stp,
		logic fz);
		int wsize, wchanged, k, n, hit, cnt;
		logic full;
		logic [63:0] sel;
		plan_beat_t b;
		wchanged = 0; k = 0; hit = 0; cnt = 0; n = int'(c_len); sel = '0;
		if (!m_delta || !c_present) begin
			plan_beats_q.push_back('{1'b0, 1'b0, 6'd0, 1'b1, 17'd0});
		end else begin
			wsize = (hi > lo) ? int'(hi) - int'(lo) : 0;
			for (int p = lo; p < hi && p < 64; p++)
				if (c_changed[p] && !(fz && p < c_frozen)) wchanged++;
			full = (m_period == 16'd0) ? (stp == 16'd0) : ((stp % m_period) == 16'd0);
			if (wsize != 0 && longint'(wchanged) * 65536 > longint'(m_fraction) * wsize)
				full = 1'b1;
			for (int p = 0; p < 64; p++) begin
				sel[p] = (p < n) && !(fz && p < c_frozen) &&
					(full || !c_valid[p] || c_changed[p]);
				if (sel[p]) k++;
			end
			if (n != 0) hit = ((n - k) * 131072 + n) / (2 * n);
			if (k == 0) begin
				plan_beats_q.push_back('{1'b1, 1'b0, 6'd0, 1'b1, 17'(hit)});
			end else begin
				for (int p = 0; p < 64; p++) begin
					if (sel[p]) begin
						cnt++;
						b = '{1'b1, 1'b1, 6'(p), cnt == k, 17'(hit)};
						plan_beats_q.push_back(b);
					end
				end
			end
		end
		c_len = '0;
		c_changed = '0;
	endtask

	// valid stays up after the accepting edge until the next beat or a pause
	task automatic send_item(logic [2:0] o, logic [5:0] pos, logic [23:0] tok,
		logic [6:0] lo = '0, logic [6:0] hi = '0, logic [15:0] stp = '0, logic fz = 1'b0,
		logic ha = 1'b0, logic kv = 1'b0);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		// plan tokens must not read never-written cache entries; c_valid guards it
		case (o)
			OP_PLAN_TOKEN: begin
				if (7'(pos) + 7'd1 > c_len) c_len = 7'(pos) + 7'd1;
				if (c_valid[pos] && c_token[pos] != tok) c_changed[pos] = 1'b1;
			end
			OP_PLAN_END: predict_plan_end(lo, hi, stp, fz);
			OP_OBSERVE_CLEAR: c_valid = '0;
			OP_OBSERVE_TOKEN: begin
				c_token[pos] = tok;
				c_valid[pos] = 1'b1;
			end
			OP_OBSERVE_END: begin
				c_present = kv;
				if (fz && ha) c_frozen = lo;
			end
			default: ;
		endcase
		in_valid      <= 1'b1;
		op            <= o;
		position      <= pos;
		token         <= tok;
		active_lo     <= lo;
		active_hi     <= hi;
		step_count    <= stp;
		freeze_en     <= fz;
		has_active    <= ha;
		kv_valid      <= kv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (plan_beats_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_MODE_DELTA: m_delta = val[0];
			CFG_PERIOD:     m_period = val[15:0];
			CFG_FRACTION:   m_fraction = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic md, logic [15:0] per, logic [16:0] frac);
		drain();
		write_cfg(CFG_MODE_DELTA, 17'(md));
		write_cfg(CFG_PERIOD, 17'(per));
		write_cfg(CFG_FRACTION, frac);
		cfg_valid <= 1'b0;
	endtask

	task automatic fill_cache(int len, logic fz, logic [6:0] bound);
		send_item(OP_OBSERVE_CLEAR, 6'd0, 24'd0);
		for (int p = 0; p < len; p++)
			send_item(OP_OBSERVE_TOKEN, 6'(p), 24'($urandom));
		send_item(OP_OBSERVE_END, 6'd0, 24'd0, bound, 7'd0, 16'd0, fz, 1'b1, 1'b1);
	endtask

	task automatic test_cold_and_off();
		// cache off, then cold cache with delta on
		send_item(OP_PLAN_TOKEN, 6'd63, 24'hFFFFFF);
		send_item(OP_PLAN_END, 6'd0, 24'd0, 7'd0, 7'd64, 16'hFFFF, 1'b1);
		set_config(1'b1, 16'd1, 17'd0);
		send_item(OP_PLAN_TOKEN, 6'd3, 24'h000000);
		send_item(OP_PLAN_END, 6'd0, 24'd0, 7'd0, 7'd10, 16'd5, 1'b0);
		send_item(3'd7, 6'h2A, 24'h555555);
		send_item(3'd5, 6'h15, 24'hAAAAAA);
	endtask

	task automatic test_directed_plans();
		set_config(1'b1, 16'd0, 17'd65536);
		fill_cache(4, 1'b1, 7'd2);
		send_item(OP_PLAN_TOKEN, 6'd0, c_token[0]);
		send_item(OP_PLAN_TOKEN, 6'd2, ~c_token[2]);
		send_item(OP_PLAN_TOKEN, 6'd5, 24'h123456);
		send_item(OP_PLAN_END, 6'd0, 24'd0, 7'd64, 7'd0, 16'd1, 1'b1);
		// empty board, period zero with step zero
		send_item(OP_PLAN_END, 6'd0, 24'd0, 7'd0, 7'd0, 16'd0, 1'b0);
		// every position unchanged gives an empty list
		send_item(OP_PLAN_TOKEN, 6'd1, c_token[1]);
		send_item(OP_PLAN_TOKEN, 6'd3, c_token[3]);
		send_item(OP_PLAN_END, 6'd0, 24'd0, 7'd0, 7'd4, 16'd7, 1'b0);
		set_config(1'b1, 16'd65535, 17'd0);
		send_item(OP_PLAN_TOKEN, 6'd1, ~c_token[1]);
		send_item(OP_PLAN_TOKEN, 6'd2, c_token[2]);
		send_item(OP_PLAN_END, 6'd0, 24'd0, 7'd0, 7'd64, 16'd65534, 1'b0);
		send_item(OP_OBSERVE_END, 6'd0, 24'd0, 7'd0, 7'd0, 16'd0, 1'b1, 1'b0, 1'b0);
		send_item(OP_PLAN_END, 6'd0, 24'd0, 7'd0, 7'd0, 16'd65535, 1'b0);
	endtask

	task automatic test_random_plans();
		int len, nitems, r;
		logic [6:0] lo, hi;
		logic [5:0] pos;
		for (int round = 0; round < 2; round++) begin
			if (round == 1) set_config(1'b1, 16'($urandom_range(1, 6)),
				17'($urandom_range(0, 65536)));
			len = $urandom_range(1, 64);
			fill_cache($urandom_range(len / 2, len), 1'($urandom_range(0, 1)),
				7'($urandom_range(0, 64)));
			repeat (3) begin
				nitems = $urandom_range(1, 10);
				for (int i = 0; i < nitems; i++) begin
					r = $urandom_range(0, 9);
					if (r < 7) begin
						pos = 6'($urandom_range(0, 63));
						send_item(OP_PLAN_TOKEN, pos,
							($urandom_range(0, 1) ? c_token[pos] : 24'($urandom)));
					end else if (r < 8) begin
						send_item(OP_OBSERVE_TOKEN, 6'($urandom), 24'($urandom));
					end else if (r < 9) begin
						send_item(3'($urandom_range(5, 7)), 6'($urandom), 24'($urandom));
					end else begin
						send_item(OP_OBSERVE_END, 6'd0, 24'd0, 7'($urandom_range(0, 64)),
							7'd0, 16'd0, 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0);
					end
				end
				lo = 7'($urandom_range(0, 64));
				hi = 7'($urandom_range(0, 64));
				send_item(OP_PLAN_END, 6'd0, 24'd0, lo, hi, 16'($urandom),
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic test_quiet_receiver();
		// sender holds off until all beats are back, receiver never stalls
		drain();
		stall_long = 1;
		fill_cache(8, 1'b0, 7'd0);
		for (int p = 0; p < 12; p++) send_item(OP_PLAN_TOKEN, 6'(p), 24'($urandom));
		send_item(OP_PLAN_END, 6'd0, 24'd0, 7'd0, 7'd12, 16'd3, 1'b0);
		drain();
		stall_long = 0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_PLAN_TOKEN;
		position = '0;
		token = '0;
		active_lo = '0;
		active_hi = '0;
		step_count = '0;
		freeze_en = 1'b0;
		has_active = 1'b0;
		kv_valid = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MODE_DELTA;
		cfg_data = '0;
		m_delta = 1'b0;
		m_period = 16'd1;
		m_fraction = '0;
		c_valid = '0;
		c_changed = '0;
		c_len = '0;
		c_frozen = '0;
		c_present = 1'b0;
		for (int i = 0; i < 64; i++) c_token[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cold_and_off();
		test_directed_plans();
		test_quiet_receiver();
		test_random_plans();
		drain();
		if (errors == 0 && plan_beats_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
